>>> src/onewire_temperature_read_master_macros.svh
// assertion macros shared by the temperature read master
`ifndef ONEWIRE_TEMPERATURE_READ_MASTER_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READ_MASTER_MACROS_SVH

`ifndef SYNTH

`define OWTR_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("owtr check failed");

`define OWTR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owtr check failed");

`else

`define OWTR_ASSERT_ALWAYS(label, clk, rst, cond)

`define OWTR_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

>>> src/owtr_pkg.sv
// shared types and constants of the 1-wire temperature read master
`timescale 1ns / 1ps

package owtr_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int READ_BITS_DEF     = 16;

  localparam int DUR_W     = 16;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam int PDATA_W   = 32;
  localparam int TEMP_W    = 15;
  localparam int RAW_W     = 16;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_START    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READ_RECOVERY = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CONVERT_WAIT  = 3'd6;

  localparam logic [DUR_W-1:0] RESET_LOW_RST     = 16'd500;
  localparam logic [DUR_W-1:0] RESET_RELEASE_RST = 16'd500;
  localparam logic [DUR_W-1:0] SLOT_START_RST    = 16'd2;
  localparam logic [DUR_W-1:0] WRITE_SLOT_RST    = 16'd60;
  localparam logic [DUR_W-1:0] READ_SAMPLE_RST   = 16'd8;
  localparam logic [DUR_W-1:0] READ_RECOVERY_RST = 16'd120;
  localparam logic [DUR_W-1:0] CONVERT_WAIT_RST  = 16'd100;

  // bus commands
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  typedef struct packed {
    logic [DUR_W-1:0] reset_low_ticks;
    logic [DUR_W-1:0] reset_release_ticks;
    logic [DUR_W-1:0] slot_start_ticks;
    logic [DUR_W-1:0] write_slot_ticks;
    logic [DUR_W-1:0] read_sample_ticks;
    logic [DUR_W-1:0] read_recovery_ticks;
    logic [DUR_W-1:0] convert_wait_ticks;
  } owtr_cfg_t;

  typedef struct packed {
    logic              drive_enable;
    logic              drive_level;
    logic              busy_res;
    logic              done_res;
    logic [TEMP_W-1:0] temperature_eighths;
  } owtr_result_t;

endpackage

>>> src/owtr_tick_if.sv
// input channel: one bus tick per item
`timescale 1ns / 1ps

interface owtr_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_level;

  modport source (output valid, output start_req, output line_level, input ready);
  modport sink (input valid, input start_req, input line_level, output ready);
endinterface

>>> src/owtr_result_if.sv
// output channel: bus drive and status per tick
`timescale 1ns / 1ps

interface owtr_result_if;
  logic                     valid;
  logic                     ready;
  logic                     drive_enable;
  logic                     drive_level;
  logic                     busy_res;
  logic                     done_res;
  logic [owtr_pkg::TEMP_W-1:0] temperature_eighths;

  modport source (output valid, output drive_enable, output drive_level, output busy_res,
                  output done_res, output temperature_eighths, input ready);
  modport sink (input valid, input drive_enable, input drive_level, input busy_res,
                input done_res, input temperature_eighths, output ready);
endinterface

>>> src/owtr_cfg_regs.sv
// apb register file holding the bus timing durations
`timescale 1ns / 1ps

module owtr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [owtr_pkg::PADDR_W-1:0] paddr,
  input  logic [owtr_pkg::PDATA_W-1:0] pwdata,
  output logic [owtr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output owtr_pkg::owtr_cfg_t          cfg
);

  logic                           wr_en;
  logic [owtr_pkg::REG_IDX_W-1:0] reg_idx;
  logic [owtr_pkg::DUR_W-1:0]     rd_val;
  logic [owtr_pkg::DUR_W-1:0]     wr_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[owtr_pkg::PADDR_W-1:2];
  assign wr_val  = pwdata[owtr_pkg::DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= owtr_pkg::RESET_LOW_RST;
      cfg.reset_release_ticks <= owtr_pkg::RESET_RELEASE_RST;
      cfg.slot_start_ticks    <= owtr_pkg::SLOT_START_RST;
      cfg.write_slot_ticks    <= owtr_pkg::WRITE_SLOT_RST;
      cfg.read_sample_ticks   <= owtr_pkg::READ_SAMPLE_RST;
      cfg.read_recovery_ticks <= owtr_pkg::READ_RECOVERY_RST;
      cfg.convert_wait_ticks  <= owtr_pkg::CONVERT_WAIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        owtr_pkg::REG_RESET_LOW:     cfg.reset_low_ticks     <= wr_val;
        owtr_pkg::REG_RESET_RELEASE: cfg.reset_release_ticks <= wr_val;
        owtr_pkg::REG_SLOT_START:    cfg.slot_start_ticks    <= wr_val;
        owtr_pkg::REG_WRITE_SLOT:    cfg.write_slot_ticks    <= wr_val;
        owtr_pkg::REG_READ_SAMPLE:   cfg.read_sample_ticks   <= wr_val;
        owtr_pkg::REG_READ_RECOVERY: cfg.read_recovery_ticks <= wr_val;
        owtr_pkg::REG_CONVERT_WAIT:  cfg.convert_wait_ticks  <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      owtr_pkg::REG_RESET_LOW:     rd_val = cfg.reset_low_ticks;
      owtr_pkg::REG_RESET_RELEASE: rd_val = cfg.reset_release_ticks;
      owtr_pkg::REG_SLOT_START:    rd_val = cfg.slot_start_ticks;
      owtr_pkg::REG_WRITE_SLOT:    rd_val = cfg.write_slot_ticks;
      owtr_pkg::REG_READ_SAMPLE:   rd_val = cfg.read_sample_ticks;
      owtr_pkg::REG_READ_RECOVERY: rd_val = cfg.read_recovery_ticks;
      owtr_pkg::REG_CONVERT_WAIT:  rd_val = cfg.convert_wait_ticks;
      default:                     rd_val = '0;
    endcase
  end

  assign prdata = owtr_pkg::PDATA_W'(rd_val);

endmodule

>>> src/owtr_sequencer.sv
// bus sequencer: one state step per accepted tick
`timescale 1ns / 1ps
`include "onewire_temperature_read_master_macros.svh"

module owtr_sequencer #(
  parameter int COUNTER_WIDTH = owtr_pkg::COUNTER_WIDTH_DEF,
  parameter int READ_BITS     = owtr_pkg::READ_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   start_req,
  input  logic                   line_level,
  input  owtr_pkg::owtr_cfg_t    cfg,
  output owtr_pkg::owtr_result_t res
);

  localparam int CMP_W = ((COUNTER_WIDTH > owtr_pkg::DUR_W) ? COUNTER_WIDTH
                                                           : owtr_pkg::DUR_W) + 1;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_R1L  = 5'd1;
  localparam logic [4:0] PH_R1R  = 5'd2;
  localparam logic [4:0] PH_WA_L = 5'd3;
  localparam logic [4:0] PH_WA_H = 5'd4;
  localparam logic [4:0] PH_WB_L = 5'd5;
  localparam logic [4:0] PH_WB_H = 5'd6;
  localparam logic [4:0] PH_CONV = 5'd7;
  localparam logic [4:0] PH_R2L  = 5'd8;
  localparam logic [4:0] PH_R2R  = 5'd9;
  localparam logic [4:0] PH_WC_L = 5'd10;
  localparam logic [4:0] PH_WC_H = 5'd11;
  localparam logic [4:0] PH_WD_L = 5'd12;
  localparam logic [4:0] PH_WD_H = 5'd13;
  localparam logic [4:0] PH_RD_L = 5'd14;
  localparam logic [4:0] PH_RD_W = 5'd15;
  localparam logic [4:0] PH_RD_R = 5'd16;

  logic [4:0]                    phase, phase_cur, phase_next;
  logic [COUNTER_WIDTH-1:0]      tick_count, tick_cur, tick_next;
  logic [3:0]                    bit_count, bit_count_next;
  logic [7:0]                    command_shift, command_shift_next;
  logic [owtr_pkg::RAW_W-1:0]    raw_shift, raw_shift_next;
  logic [owtr_pkg::TEMP_W-1:0]   held_temperature, held_temperature_next;
  logic [owtr_pkg::DUR_W-1:0]    dur;
  logic [CMP_W-1:0]              tick_inc;
  logic                          last;
  logic                          busy;
  logic                          drv_en, drv_lvl, done;

  // idle or a stray code: a start makes this tick the first reset-low tick
  always_comb begin
    phase_cur = phase;
    tick_cur  = tick_count;
    if (phase == PH_IDLE || phase > PH_RD_R) begin
      phase_cur = PH_IDLE;
      if (start_req) begin
        phase_cur = PH_R1L;
        tick_cur  = '0;
      end
    end
  end

  always_comb begin
    case (phase_cur)
      PH_R1L, PH_R2L:                            dur = cfg.reset_low_ticks;
      PH_R1R, PH_R2R:                            dur = cfg.reset_release_ticks;
      PH_WA_L, PH_WB_L, PH_WC_L, PH_WD_L, PH_RD_L: dur = cfg.slot_start_ticks;
      PH_WA_H, PH_WB_H, PH_WC_H, PH_WD_H:        dur = cfg.write_slot_ticks;
      PH_RD_W:                                   dur = cfg.read_sample_ticks;
      PH_RD_R:                                   dur = cfg.read_recovery_ticks;
      default:                                   dur = cfg.convert_wait_ticks;
    endcase
  end

  // a zero duration acts as one tick; an all-ones count ends the phase (saturation)
  assign tick_inc = CMP_W'(tick_cur) + CMP_W'(1);
  assign last     = (tick_inc >= CMP_W'(dur)) || (&tick_cur);
  assign busy     = (phase_cur != PH_IDLE);

  always_comb begin
    drv_en  = 1'b0;
    drv_lvl = 1'b1;
    case (phase_cur)
      PH_R1L, PH_R2L, PH_WA_L, PH_WB_L, PH_WC_L, PH_WD_L, PH_RD_L: begin
        drv_en  = 1'b1;
        drv_lvl = 1'b0;
      end
      PH_WA_H, PH_WB_H, PH_WC_H, PH_WD_H: begin
        drv_en  = 1'b1;
        drv_lvl = command_shift[0];
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_next            = phase_cur;
    tick_next             = tick_cur;
    bit_count_next        = bit_count;
    command_shift_next    = command_shift;
    raw_shift_next        = raw_shift;
    held_temperature_next = held_temperature;
    done                  = 1'b0;
    if (busy) begin
      tick_next = tick_inc[COUNTER_WIDTH-1:0];
      if (phase_cur == PH_RD_W && last) begin
        // sampled bit enters at the top, then the whole word moves down
        raw_shift_next = {1'b0, line_level | raw_shift[owtr_pkg::RAW_W-1],
                          raw_shift[owtr_pkg::RAW_W-2:1]};
      end
      if (last) begin
        tick_next = '0;
        case (phase_cur)
          PH_R1R: begin
            phase_next         = PH_WA_L;
            command_shift_next = owtr_pkg::CMD_SKIP_ROM;
            bit_count_next     = '0;
          end
          PH_R2R: begin
            phase_next         = PH_WC_L;
            command_shift_next = owtr_pkg::CMD_SKIP_ROM;
            bit_count_next     = '0;
          end
          PH_WA_H, PH_WB_H, PH_WC_H, PH_WD_H: begin
            command_shift_next = {1'b0, command_shift[7:1]};
            if (bit_count >= 4'd7) begin
              case (phase_cur)
                PH_WA_H: begin
                  phase_next         = PH_WB_L;
                  command_shift_next = owtr_pkg::CMD_CONVERT;
                  bit_count_next     = '0;
                end
                PH_WC_H: begin
                  phase_next         = PH_WD_L;
                  command_shift_next = owtr_pkg::CMD_READ_SCRATCH;
                  bit_count_next     = '0;
                end
                PH_WB_H: phase_next = PH_CONV;
                default: begin
                  phase_next     = PH_RD_L;
                  bit_count_next = '0;
                  raw_shift_next = '0;
                end
              endcase
            end else begin
              bit_count_next = bit_count + 4'd1;
              phase_next     = phase_cur - 5'd1;
            end
          end
          PH_RD_R: begin
            if (bit_count >= 4'(READ_BITS - 1)) begin
              held_temperature_next = raw_shift[owtr_pkg::TEMP_W-1:0];
              done                  = 1'b1;
              phase_next            = PH_IDLE;
            end else begin
              bit_count_next = bit_count + 4'd1;
              phase_next     = PH_RD_L;
            end
          end
          default: phase_next = phase_cur + 5'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_count        <= '0;
      command_shift    <= '0;
      raw_shift        <= '0;
      held_temperature <= '0;
    end else if (step) begin
      phase            <= phase_next;
      tick_count       <= tick_next;
      bit_count        <= bit_count_next;
      command_shift    <= command_shift_next;
      raw_shift        <= raw_shift_next;
      held_temperature <= held_temperature_next;
    end
  end

  assign res.drive_enable        = drv_en;
  assign res.drive_level         = drv_lvl;
  assign res.busy_res            = busy;
  assign res.done_res            = done;
  assign res.temperature_eighths = held_temperature_next;

  `OWTR_ASSERT_ALWAYS(a_phase_known, clk, rst, phase <= PH_RD_R)
  `OWTR_ASSERT_IMPLIES(a_done_from_recovery, clk, rst, step && done,
                       phase == PH_RD_R && busy)
  `OWTR_ASSERT_IMPLIES(a_write_bits_in_byte, clk, rst,
                       phase == PH_WA_H || phase == PH_WB_H || phase == PH_WC_H ||
                       phase == PH_WD_H, bit_count <= 4'd7)

endmodule

>>> src/owtr_out_buf.sv
// two-entry result buffer so one stalled result does not block the next tick
`timescale 1ns / 1ps
`include "onewire_temperature_read_master_macros.svh"

module owtr_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   push_ready,
  input  owtr_pkg::owtr_result_t push_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output owtr_pkg::owtr_result_t out_data
);

  owtr_pkg::owtr_result_t skid_data;
  logic                   skid_valid;
  logic                   pop;

  assign pop        = out_valid & out_ready;
  assign push_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  `OWTR_ASSERT_ALWAYS(a_skid_behind_head, clk, rst, !skid_valid || out_valid)
  `OWTR_ASSERT_IMPLIES(a_skid_holds, clk, rst, skid_valid && !out_ready,
                       ##1 skid_valid && $stable(skid_data))
  `OWTR_ASSERT_IMPLIES(a_no_push_when_full, clk, rst, skid_valid, !push)

endmodule

>>> src/onewire_temperature_read_master.sv
// top level of the 1-wire temperature read master
//
//   port group   dir   items
//   tick         in    start_req, line_level: one bus tick per item
//   result       out   drive_enable, drive_level, busy_res, done_res, temperature_eighths
//   apb          in    seven 16-bit timing registers at byte address 4*i
//
// one tick item per clock while tick.ready is high; each item gives one result item, registered in the output buffer
// the sequencer state update is a single pass of logic from its state registers
// a two-entry output buffer keeps ticks flowing while one result waits
// rst is synchronous: idle sequence, zero reading, timing registers at defaults
// tick.ready drops only when both buffer entries hold results
`timescale 1ns / 1ps

module onewire_temperature_read_master #(
  parameter int COUNTER_WIDTH = owtr_pkg::COUNTER_WIDTH_DEF,
  parameter int READ_BITS     = owtr_pkg::READ_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  owtr_tick_if.sink                    tick,
  owtr_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [owtr_pkg::PADDR_W-1:0] paddr,
  input  logic [owtr_pkg::PDATA_W-1:0] pwdata,
  output logic [owtr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  owtr_pkg::owtr_cfg_t    cfg;
  owtr_pkg::owtr_result_t seq_res;
  owtr_pkg::owtr_result_t buf_data;
  logic                   step;
  logic                   buf_ready;

  assign tick.ready = buf_ready;
  assign step       = tick.valid & buf_ready;

  owtr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owtr_sequencer #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .READ_BITS     (READ_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_req  (tick.start_req),
    .line_level (tick.line_level),
    .cfg        (cfg),
    .res        (seq_res)
  );

  owtr_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_ready (buf_ready),
    .push_data  (seq_res),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_data   (buf_data)
  );

  assign result.drive_enable        = buf_data.drive_enable;
  assign result.drive_level         = buf_data.drive_level;
  assign result.busy_res            = buf_data.busy_res;
  assign result.done_res            = buf_data.done_res;
  assign result.temperature_eighths = buf_data.temperature_eighths;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the 1-wire temperature read master
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 600_000;
  localparam int RANDOM_TICKS = 400;
  localparam int SHOWN_MISMATCHES = 10;
  // one past the last register, must be ignored by the block
  localparam logic [owtr_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [4:0] {
    SEQ_IDLE, SEQ_RST1_LOW, SEQ_RST1_REL, SEQ_SKIP1_LOW, SEQ_SKIP1_HOLD,
    SEQ_CONV_LOW, SEQ_CONV_HOLD, SEQ_CONV_WAIT, SEQ_RST2_LOW, SEQ_RST2_REL,
    SEQ_SKIP2_LOW, SEQ_SKIP2_HOLD, SEQ_RDCMD_LOW, SEQ_RDCMD_HOLD,
    SEQ_SLOT_LOW, SEQ_SLOT_WAIT, SEQ_SLOT_RECOVER
  } seq_phase_t;

  typedef enum logic [1:0] {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_mode_t;

  typedef struct packed {
    logic                   start;
    logic                   line;
    logic                   typed;
    owtr_pkg::owtr_result_t res;
  } tick_row_t;

  localparam owtr_pkg::owtr_result_t RES_IDLE = '{drive_enable: 1'b0, drive_level: 1'b1,
                                                  busy_res: 1'b0, done_res: 1'b0,
                                                  temperature_eighths: '0};
  localparam owtr_pkg::owtr_result_t RES_RST_LOW = '{drive_enable: 1'b1, drive_level: 1'b0,
                                                     busy_res: 1'b1, done_res: 1'b0,
                                                     temperature_eighths: '0};

  // the directed part runs with a 20-tick reset low phase, so early rows are known
  localparam int N_ROWS = 12;
  localparam tick_row_t DIRECTED_TICKS [N_ROWS] = '{
    '{start: 1'b0, line: 1'b0, typed: 1'b1, res: RES_IDLE},
    '{start: 1'b0, line: 1'b1, typed: 1'b1, res: RES_IDLE},
    '{start: 1'b0, line: 1'b0, typed: 1'b0, res: '0},
    '{start: 1'b1, line: 1'b0, typed: 1'b1, res: RES_RST_LOW},
    '{start: 1'b1, line: 1'b1, typed: 1'b1, res: RES_RST_LOW},
    '{start: 1'b0, line: 1'b1, typed: 1'b1, res: RES_RST_LOW},
    '{start: 1'b1, line: 1'b0, typed: 1'b0, res: '0},
    '{start: 1'b0, line: 1'b0, typed: 1'b1, res: RES_RST_LOW},
    '{start: 1'b1, line: 1'b1, typed: 1'b0, res: '0},
    '{start: 1'b0, line: 1'b1, typed: 1'b0, res: '0},
    '{start: 1'b1, line: 1'b0, typed: 1'b1, res: RES_RST_LOW},
    '{start: 1'b0, line: 1'b0, typed: 1'b0, res: '0}
  };

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [owtr_pkg::PADDR_W-1:0]   paddr;
  logic [owtr_pkg::PDATA_W-1:0]   pwdata;
  logic [owtr_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  owtr_tick_if   tick_ch ();
  owtr_result_if res_ch ();

  onewire_temperature_read_master uut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // sequencer mirror
  owtr_pkg::owtr_cfg_t         timing;
  seq_phase_t                  seq_ph;
  logic [owtr_pkg::DUR_W-1:0]  tick_cnt;
  logic [3:0]                  bit_cnt;
  logic [7:0]                  cmd_sr;
  logic [owtr_pkg::RAW_W-1:0]  raw_sr;
  logic [owtr_pkg::TEMP_W-1:0] held_temp;

  owtr_pkg::owtr_result_t bus_results_due [$];

  logic calm;
  int   mismatches;
  int   results_seen;
  int   ticks_sent;
  int   busy_ticks;
  int   reads_done;
  int   reg_accesses;
  int   settings_run;
  int   cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               bus_results_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) $display("mismatch: %s", msg);
  endtask

  function automatic string res_str(input owtr_pkg::owtr_result_t r);
    return $sformatf("en=%b lvl=%b busy=%b done=%b temp=%0d", r.drive_enable,
                     r.drive_level, r.busy_res, r.done_res, r.temperature_eighths);
  endfunction

  // gap lengths: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [owtr_pkg::DUR_W-1:0] field_of(
      input owtr_pkg::owtr_cfg_t c, input logic [owtr_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      owtr_pkg::REG_RESET_LOW:     return c.reset_low_ticks;
      owtr_pkg::REG_RESET_RELEASE: return c.reset_release_ticks;
      owtr_pkg::REG_SLOT_START:    return c.slot_start_ticks;
      owtr_pkg::REG_WRITE_SLOT:    return c.write_slot_ticks;
      owtr_pkg::REG_READ_SAMPLE:   return c.read_sample_ticks;
      owtr_pkg::REG_READ_RECOVERY: return c.read_recovery_ticks;
      owtr_pkg::REG_CONVERT_WAIT:  return c.convert_wait_ticks;
      default:                     return '0;
    endcase
  endfunction

  task automatic set_timing(input logic [owtr_pkg::REG_IDX_W-1:0] idx,
                            input logic [owtr_pkg::DUR_W-1:0] val);
    case (idx)
      owtr_pkg::REG_RESET_LOW:     timing.reset_low_ticks = val;
      owtr_pkg::REG_RESET_RELEASE: timing.reset_release_ticks = val;
      owtr_pkg::REG_SLOT_START:    timing.slot_start_ticks = val;
      owtr_pkg::REG_WRITE_SLOT:    timing.write_slot_ticks = val;
      owtr_pkg::REG_READ_SAMPLE:   timing.read_sample_ticks = val;
      owtr_pkg::REG_READ_RECOVERY: timing.read_recovery_ticks = val;
      owtr_pkg::REG_CONVERT_WAIT:  timing.convert_wait_ticks = val;
      default: ;
    endcase
  endtask

  function automatic logic [owtr_pkg::DUR_W:0] duration_of(input seq_phase_t p);
    logic [owtr_pkg::DUR_W-1:0] d;
    case (p)
      SEQ_RST1_LOW, SEQ_RST2_LOW: d = timing.reset_low_ticks;
      SEQ_RST1_REL, SEQ_RST2_REL: d = timing.reset_release_ticks;
      SEQ_SKIP1_LOW, SEQ_CONV_LOW, SEQ_SKIP2_LOW, SEQ_RDCMD_LOW, SEQ_SLOT_LOW:
        d = timing.slot_start_ticks;
      SEQ_SKIP1_HOLD, SEQ_CONV_HOLD, SEQ_SKIP2_HOLD, SEQ_RDCMD_HOLD:
        d = timing.write_slot_ticks;
      SEQ_SLOT_WAIT:    d = timing.read_sample_ticks;
      SEQ_SLOT_RECOVER: d = timing.read_recovery_ticks;
      default:          d = timing.convert_wait_ticks;
    endcase
    // a zero duration still takes one tick
    return (d == '0) ? {{owtr_pkg::DUR_W{1'b0}}, 1'b1} : {1'b0, d};
  endfunction

  task automatic load_byte(input seq_phase_t low_ph, input logic [7:0] cmd);
    seq_ph = low_ph;
    cmd_sr = cmd;
    bit_cnt = '0;
  endtask

  // one tick of the sequencer; gives the bus and status outputs for that tick
  task automatic advance_sequencer(input logic start, input logic line,
                                   output owtr_pkg::owtr_result_t r);
    logic [owtr_pkg::DUR_W:0] nxt;
    logic                     last;
    r = RES_IDLE;
    if (seq_ph == SEQ_IDLE && start) begin
      seq_ph = SEQ_RST1_LOW;
      tick_cnt = '0;
    end
    case (seq_ph)
      SEQ_RST1_LOW, SEQ_RST2_LOW, SEQ_SKIP1_LOW, SEQ_CONV_LOW, SEQ_SKIP2_LOW,
      SEQ_RDCMD_LOW, SEQ_SLOT_LOW: begin
        r.drive_enable = 1'b1;
        r.drive_level = 1'b0;
      end
      SEQ_SKIP1_HOLD, SEQ_CONV_HOLD, SEQ_SKIP2_HOLD, SEQ_RDCMD_HOLD: begin
        r.drive_enable = 1'b1;
        r.drive_level = cmd_sr[0];
      end
      default: ;
    endcase
    r.busy_res = (seq_ph != SEQ_IDLE);
    if (r.busy_res) begin
      nxt = {1'b0, tick_cnt} + 1'b1;
      last = (nxt >= duration_of(seq_ph));
      tick_cnt = nxt[owtr_pkg::DUR_W-1:0];
      // sampled bit enters at the top, then the whole word moves right
      if (seq_ph == SEQ_SLOT_WAIT && last)
        raw_sr = {1'b0, raw_sr[owtr_pkg::RAW_W-1] | line, raw_sr[owtr_pkg::RAW_W-2:1]};
      if (last) begin
        tick_cnt = '0;
        case (seq_ph)
          SEQ_RST1_REL: load_byte(SEQ_SKIP1_LOW, owtr_pkg::CMD_SKIP_ROM);
          SEQ_RST2_REL: load_byte(SEQ_SKIP2_LOW, owtr_pkg::CMD_SKIP_ROM);
          SEQ_SKIP1_HOLD, SEQ_CONV_HOLD, SEQ_SKIP2_HOLD, SEQ_RDCMD_HOLD: begin
            cmd_sr = cmd_sr >> 1;
            if (bit_cnt >= 4'd7) begin
              case (seq_ph)
                SEQ_SKIP1_HOLD: load_byte(SEQ_CONV_LOW, owtr_pkg::CMD_CONVERT);
                SEQ_SKIP2_HOLD: load_byte(SEQ_RDCMD_LOW, owtr_pkg::CMD_READ_SCRATCH);
                SEQ_CONV_HOLD:  seq_ph = SEQ_CONV_WAIT;
                default: begin
                  seq_ph = SEQ_SLOT_LOW;
                  bit_cnt = '0;
                  raw_sr = '0;
                end
              endcase
            end else begin
              bit_cnt = bit_cnt + 1'b1;
              seq_ph = seq_phase_t'(seq_ph - 1);
            end
          end
          SEQ_SLOT_RECOVER: begin
            if (bit_cnt >= 4'(owtr_pkg::READ_BITS_DEF - 1)) begin
              held_temp = raw_sr[owtr_pkg::TEMP_W-1:0];
              r.done_res = 1'b1;
              seq_ph = SEQ_IDLE;
            end else begin
              bit_cnt = bit_cnt + 1'b1;
              seq_ph = SEQ_SLOT_LOW;
            end
          end
          default: seq_ph = seq_phase_t'(seq_ph + 1);
        endcase
      end
    end
    r.temperature_eighths = held_temp;
  endtask

  task automatic send_tick(input logic start, input logic line, input logic typed,
                           input owtr_pkg::owtr_result_t typed_res);
    int                     gap;
    owtr_pkg::owtr_result_t want;
    gap = idle_len();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.start_req <= start;
    tick_ch.line_level <= line;
    do @(posedge clk); while (!tick_ch.ready);
    advance_sequencer(start, line, want);
    bus_results_due.push_back(typed ? typed_res : want);
    ticks_sent++;
    if (want.busy_res) busy_ticks++;
    if (want.done_res) reads_done++;
  endtask

  function automatic logic line_bit(input line_mode_t mode);
    case (mode)
      LINE_HIGH: return 1'b1;
      LINE_LOW:  return 1'b0;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // hold the sender until every result is in and the block has settled
  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (bus_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic finish_read(input line_mode_t mode);
    while (seq_ph != SEQ_IDLE)
      send_tick(1'($urandom_range(0, 3) == 0), line_bit(mode), 1'b0, '0);
  endtask

  task automatic apb_write(input logic [owtr_pkg::REG_IDX_W-1:0] idx,
                           input logic [owtr_pkg::DUR_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(owtr_pkg::PDATA_W-owtr_pkg::DUR_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    set_timing(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_accesses++;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [owtr_pkg::REG_IDX_W-1:0] idx);
    logic [owtr_pkg::PDATA_W-1:0] want;
    want = {{(owtr_pkg::PDATA_W-owtr_pkg::DUR_W){1'b0}}, field_of(timing, idx)};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_mismatch($sformatf("register %0d read: exp %h got %h", idx, want, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    reg_accesses++;
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    for (int k = 0; k <= owtr_pkg::REG_CONVERT_WAIT; k++)
      apb_check(owtr_pkg::REG_IDX_W'(k));
  endtask

  task automatic apply_timing(input owtr_pkg::owtr_cfg_t c);
    for (int k = 0; k <= owtr_pkg::REG_CONVERT_WAIT; k++)
      apb_write(owtr_pkg::REG_IDX_W'(k), field_of(c, owtr_pkg::REG_IDX_W'(k)));
    check_all_regs();
    settings_run++;
  endtask

  // one setting: a batch of ticks starting a read, maybe a hold-off inside it, then run out
  task automatic run_setting(input owtr_pkg::owtr_cfg_t c, input int n_ticks,
                             input line_mode_t mode);
    int hold_at;
    apply_timing(c);
    hold_at = $urandom_range(1, n_ticks);
    for (int i = 0; i < n_ticks; i++) begin
      if (i == hold_at) wait_drained();
      send_tick((i == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0), line_bit(mode), 1'b0, '0);
    end
    finish_read(mode);
    wait_drained();
  endtask

  function automatic logic [owtr_pkg::DUR_W-1:0] short_dur();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 8) return owtr_pkg::DUR_W'($urandom_range(1, 3));
    return owtr_pkg::DUR_W'($urandom_range(4, 12));
  endfunction

  function automatic owtr_pkg::owtr_cfg_t uniform_timing(input logic [owtr_pkg::DUR_W-1:0] v);
    owtr_pkg::owtr_cfg_t c;
    c.reset_low_ticks = v;
    c.reset_release_ticks = v;
    c.slot_start_ticks = v;
    c.write_slot_ticks = v;
    c.read_sample_ticks = v;
    c.read_recovery_ticks = v;
    c.convert_wait_ticks = v;
    return c;
  endfunction

  // result side: check accepted items, then pick ready for the next edge
  int out_stall;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (bus_results_due.size() == 0) begin
          note_mismatch($sformatf("result item %0d arrived with nothing pending",
                                  results_seen));
        end else begin
          owtr_pkg::owtr_result_t want;
          owtr_pkg::owtr_result_t got;
          want = bus_results_due.pop_front();
          got.drive_enable = res_ch.drive_enable;
          got.drive_level = res_ch.drive_level;
          got.busy_res = res_ch.busy_res;
          got.done_res = res_ch.done_res;
          got.temperature_eighths = res_ch.temperature_eighths;
          if (got !== want)
            note_mismatch($sformatf("item %0d exp %s got %s", results_seen,
                                    res_str(want), res_str(got)));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        out_stall = idle_len();
        res_ch.ready <= (out_stall == 0);
      end
    end
  end

  initial begin
    owtr_pkg::owtr_cfg_t c;
    line_mode_t          mode;
    int                  busy_mark;
    int                  reads_mark;
    int                  pick;

    rst <= 1'b1;
    tick_ch.valid <= 1'b0;
    tick_ch.start_req <= 1'b0;
    tick_ch.line_level <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    timing = '{reset_low_ticks: owtr_pkg::RESET_LOW_RST,
               reset_release_ticks: owtr_pkg::RESET_RELEASE_RST,
               slot_start_ticks: owtr_pkg::SLOT_START_RST,
               write_slot_ticks: owtr_pkg::WRITE_SLOT_RST,
               read_sample_ticks: owtr_pkg::READ_SAMPLE_RST,
               read_recovery_ticks: owtr_pkg::READ_RECOVERY_RST,
               convert_wait_ticks: owtr_pkg::CONVERT_WAIT_RST};
    seq_ph = SEQ_IDLE;
    tick_cnt = '0;
    bit_cnt = '0;
    cmd_sr = '0;
    raw_sr = '0;
    held_temp = '0;
    calm = 1'b0;
    mismatches = 0;
    results_seen = 0;
    ticks_sent = 0;
    busy_ticks = 0;
    reads_done = 0;
    reg_accesses = 0;
    settings_run = 0;
    cycles = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, then the known rows at a compact timing, then finish that read
    check_all_regs();
    c = uniform_timing(16'd1);
    c.reset_low_ticks = 16'd20;
    apply_timing(c);
    for (int i = 0; i < N_ROWS; i++)
      send_tick(DIRECTED_TICKS[i].start, DIRECTED_TICKS[i].line, DIRECTED_TICKS[i].typed,
                DIRECTED_TICKS[i].res);
    finish_read(LINE_RANDOM);
    wait_drained();

    // register bits both ways, and a write past the last register
    for (int k = 0; k <= owtr_pkg::REG_CONVERT_WAIT; k++)
      apb_write(owtr_pkg::REG_IDX_W'(k), 16'hAAAA);
    check_all_regs();
    for (int k = 0; k <= owtr_pkg::REG_CONVERT_WAIT; k++)
      apb_write(owtr_pkg::REG_IDX_W'(k), 16'h5555);
    check_all_regs();
    apb_write(REG_UNUSED, 16'hFFFF);
    check_all_regs();

    // fixed settings: shortest, zero durations, longer waits, wider slots
    run_setting(uniform_timing(16'd1), 200, LINE_HIGH);
    run_setting(uniform_timing(16'd0), 200, LINE_LOW);
    calm = 1'b1;
    c = uniform_timing(16'd1);
    c.reset_low_ticks = 16'd40;
    c.convert_wait_ticks = 16'd60;
    run_setting(c, 1, LINE_RANDOM);
    c = uniform_timing(16'd1);
    c.reset_release_ticks = 16'd50;
    run_setting(c, 1, LINE_HIGH);
    c = uniform_timing(16'd1);
    c.write_slot_ticks = 16'd3;
    c.read_sample_ticks = 16'd4;
    c.read_recovery_ticks = 16'd5;
    run_setting(c, 1, LINE_RANDOM);
    calm = 1'b0;

    // random short timings with random bus content
    busy_mark = busy_ticks;
    reads_mark = reads_done;
    while (busy_ticks - busy_mark < RANDOM_TICKS || reads_done - reads_mark < 1) begin
      c.reset_low_ticks = short_dur();
      c.reset_release_ticks = short_dur();
      c.slot_start_ticks = short_dur();
      c.write_slot_ticks = short_dur();
      c.read_sample_ticks = short_dur();
      c.read_recovery_ticks = short_dur();
      c.convert_wait_ticks = short_dur();
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      mode = (pick < 14) ? LINE_RANDOM : ((pick < 17) ? LINE_HIGH : LINE_LOW);
      run_setting(c, 300, mode);
    end
    calm = 1'b0;

    repeat (16) @(posedge clk);
    $display("%0d tick items sent, %0d of them during a read, %0d results checked",
             ticks_sent, busy_ticks, results_seen);
    $display("%0d temperature reads over %0d timing settings, %0d register accesses",
             reads_done, settings_run, reg_accesses);
    if (mismatches == 0 && bus_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/owtr_pkg.sv
src/owtr_tick_if.sv
src/owtr_result_if.sv
src/owtr_cfg_regs.sv
src/owtr_sequencer.sv
src/owtr_out_buf.sv
src/onewire_temperature_read_master.sv
tb/tb_top.sv
